// ===== hw/rtl/afc_pkg.sv =====
package afc_pkg;

  localparam int PlaneCount   = 4;
  localparam int CoordBits    = 16;
  localparam int NumPlaneRegs = 4;
  localparam int PlaneW       = 64;
  localparam int FieldW       = 16;
  localparam int NormFracBits = 14;
  localparam int CfgIdxW      = 4;
  localparam int PlaneIdxW    = $clog2(NumPlaneRegs);

  // control that travels with an item from cell to cell
  typedef struct packed {
    logic valid;
    logic vis;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/aabb_frustum_cull.sv =====
// channel   direction  handshake             payload
// item in   input      start_i & !busy_o     box_{x,y,z}_{min,max}_i, lane_active_i
// result    output     done_o (one cycle)    visible_o
// config    input      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One item per cycle; each result comes out of a chain of min(PLANE_COUNT, 4)
// plane cells, two register stages per plane cell (multiply, then
// add and compare). busy_o stays low: the cell chain never holds an item off.
// Reset clears the plane registers and the valid bits of the chain.
// The receiver cannot stall; done_o is a one-cycle strobe.
module aabb_frustum_cull #(
  parameter int PLANE_COUNT = afc_pkg::PlaneCount,
  parameter int COORD_BITS  = afc_pkg::CoordBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [COORD_BITS-1:0]    box_x_min_i,
  input  logic signed [COORD_BITS-1:0]    box_x_max_i,
  input  logic signed [COORD_BITS-1:0]    box_y_min_i,
  input  logic signed [COORD_BITS-1:0]    box_y_max_i,
  input  logic signed [COORD_BITS-1:0]    box_z_min_i,
  input  logic signed [COORD_BITS-1:0]    box_z_max_i,
  input  logic                            lane_active_i,
  output logic                            done_o,
  output logic                            visible_o,
  input  logic                            cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [afc_pkg::PlaneW-1:0]      cfg_wdata_i
);
  import afc_pkg::*;

  localparam int CellCount = (PLANE_COUNT < NumPlaneRegs) ? PLANE_COUNT : NumPlaneRegs;

  logic [PlaneW-1:0]            plane_q [NumPlaneRegs];
  cell_ctl_t                    ctl_w [CellCount+1];
  logic signed [COORD_BITS-1:0] lo_w  [CellCount+1][3];
  logic signed [COORD_BITS-1:0] hi_w  [CellCount+1][3];

  // writes to an index past the plane list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPlaneRegs; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumPlaneRegs))) begin
      plane_q[cfg_idx_i[PlaneIdxW-1:0]] <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  // vis only rides along with a valid item
  assign ctl_w[0].valid = start_i & ~busy_o;
  assign ctl_w[0].vis   = lane_active_i & ctl_w[0].valid;
  assign lo_w[0][0]     = box_x_min_i;
  assign hi_w[0][0]     = box_x_max_i;
  assign lo_w[0][1]     = box_y_min_i;
  assign hi_w[0][1]     = box_y_max_i;
  assign lo_w[0][2]     = box_z_min_i;
  assign hi_w[0][2]     = box_z_max_i;

  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    afc_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .plane_i(plane_q[g]),
      .ctl_i  (ctl_w[g]),
      .lo_i   (lo_w[g]),
      .hi_i   (hi_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .lo_o   (lo_w[g+1]),
      .hi_o   (hi_w[g+1])
    );
  end

  assign done_o    = ctl_w[CellCount].valid;
  assign visible_o = ctl_w[CellCount].vis;

endmodule

// ===== hw/rtl/afc_cell.sv =====
module afc_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [afc_pkg::PlaneW-1:0]     plane_i,
  input  afc_pkg::cell_ctl_t             ctl_i,
  input  logic signed [COORD_BITS-1:0]   lo_i [3],
  input  logic signed [COORD_BITS-1:0]   hi_i [3],
  output afc_pkg::cell_ctl_t             ctl_o,
  output logic signed [COORD_BITS-1:0]   lo_o [3],
  output logic signed [COORD_BITS-1:0]   hi_o [3]
);
  import afc_pkg::*;

  localparam int ProdW   = COORD_BITS + FieldW;
  localparam int SumW    = COORD_BITS + FieldW + 2;
  localparam int ScaledW = FieldW + NormFracBits;
  localparam int DotW    = (SumW > ScaledW) ? SumW : ScaledW;

  logic signed [FieldW-1:0]     norm_w   [3];
  logic signed [COORD_BITS-1:0] corner_w [3];
  logic signed [ProdW-1:0]      prod_d   [3];
  logic signed [ProdW-1:0]      prod_q   [3];

  cell_ctl_t                    ctl_s1_q;
  logic signed [COORD_BITS-1:0] lo_s1_q [3];
  logic signed [COORD_BITS-1:0] hi_s1_q [3];

  cell_ctl_t                    ctl_s2_q;
  logic signed [COORD_BITS-1:0] lo_s2_q [3];
  logic signed [COORD_BITS-1:0] hi_s2_q [3];

  logic signed [FieldW-1:0]     dist_w;
  logic signed [DotW-1:0]       dot_w;
  logic signed [DotW-1:0]       dist_scaled_w;
  logic                         pass_w;

  // p-vertex: negative normal component picks the min corner
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      norm_w[a]   = $signed(plane_i[FieldW*a +: FieldW]);
      corner_w[a] = norm_w[a][FieldW-1] ? lo_i[a] : hi_i[a];
      prod_d[a]   = ProdW'(norm_w[a]) * ProdW'(corner_w[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s1_q <= '0;
    end else begin
      ctl_s1_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    lo_s1_q <= lo_i;
    hi_s1_q <= hi_i;
  end

  // the user must change plane registers only while no item is in flight; the block itself does not enforce this
  assign dist_w        = $signed(plane_i[PlaneW-1 -: FieldW]);
  assign dot_w         = DotW'(prod_q[0]) + DotW'(prod_q[1]) + DotW'(prod_q[2]);
  assign dist_scaled_w = DotW'($signed({dist_w, {NormFracBits{1'b0}}}));
  assign pass_w        = dist_scaled_w < dot_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s2_q <= '0;
    end else begin
      ctl_s2_q.valid <= ctl_s1_q.valid;
      ctl_s2_q.vis   <= ctl_s1_q.vis & pass_w;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_s2_q <= lo_s1_q;
    hi_s2_q <= hi_s1_q;
  end

  assign ctl_o = ctl_s2_q;
  assign lo_o  = lo_s2_q;
  assign hi_o  = hi_s2_q;

endmodule

// ===== hw/rtl/afc_checker.sv =====
module afc_checker #(
  parameter int PLANE_COUNT = afc_pkg::PlaneCount
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic lane_active_i,
  input logic done_o,
  input logic visible_o
);
  import afc_pkg::*;

  localparam int CellCount = (PLANE_COUNT < NumPlaneRegs) ? PLANE_COUNT : NumPlaneRegs;
  localparam int Lat       = 2 * CellCount;

  logic accept_w;
  assign accept_w = start_i & ~busy_o;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined chain");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |-> ##Lat done_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept_w, Lat))
    else $error("result without a matching item");

  a_inactive_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_w && !lane_active_i) |-> ##Lat !visible_o)
    else $error("inactive item reported visible");

  a_vis_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visible_o |-> done_o)
    else $error("visible outside a result cycle");

endmodule

bind aabb_frustum_cull afc_checker #(
  .PLANE_COUNT(PLANE_COUNT)
) u_afc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .lane_active_i(lane_active_i),
  .done_o       (done_o),
  .visible_o    (visible_o)
);
